FILE: design/bsb_pkg.sv
// Shared types, widths and helpers for the bounding sphere builder.
// No dependencies; used by every module in the design folder.
package bsb_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 24;
  localparam int RAD_W        = 26;
  localparam int DSQ_W        = 2 * RAD_W;
  localparam int MUL_W        = RAD_W + 1;
  localparam int PROD_W       = 2 * MUL_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec3_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef enum logic [1:0] {
    PASS_A,
    PASS_B,
    PASS_DD,
    PASS_GROW
  } pass_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FIRST,
    ST_FIRSTW,
    ST_RD,
    ST_SQ,
    ST_SUM,
    ST_CMP,
    ST_INIT,
    ST_SQRT,
    ST_R2,
    ST_R2W,
    ST_GMUL,
    ST_DIVS,
    ST_DIV,
    ST_FIN
  } state_t;

  function automatic logic signed [COORD_W-1:0] axis_of(vec3_t v, axis_t ax);
    case (ax)
      AX_X:    return v.x;
      AX_Y:    return v.y;
      default: return v.z;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [COORD_W+2:0] v);
    logic signed [COORD_W+2:0] hi;
    logic signed [COORD_W+2:0] lo;
    hi = (COORD_W+3)'(2 ** (COORD_W - 1) - 1);
    lo = -(COORD_W+3)'(2 ** (COORD_W - 1));
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage

FILE: design/bsb_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on bsb_pkg for widths.
module bsb_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bsb_pkg::DSQ_W-1:0] radicand,
  output logic                      done,
  output logic [bsb_pkg::RAD_W-1:0] root
);
  import bsb_pkg::*;

  localparam int CW = $clog2(RAD_W + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [DSQ_W-1:0] n_r, n_nxt;
  logic [RAD_W+1:0] rem_r, rem_nxt;
  logic [RAD_W-1:0] root_r, root_nxt;
  logic [RAD_W+1:0] rem_sh, trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r[RAD_W-1:0], n_r[DSQ_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(RAD_W);
      n_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      n_nxt = {n_r[DSQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RAD_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RAD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: design/bsb_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bsb_pkg for widths.
module bsb_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bsb_pkg::DSQ_W-1:0] dividend,
  input  logic [bsb_pkg::RAD_W-1:0] divisor,
  output logic                      done,
  output logic [bsb_pkg::RAD_W-1:0] quotient
);
  import bsb_pkg::*;

  localparam int CW = $clog2(DSQ_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DSQ_W-1:0] q_r, q_nxt;
  logic [RAD_W-1:0] dsr_r, dsr_nxt;
  logic [RAD_W-1:0] rem_r, rem_nxt;
  logic [RAD_W:0]   rem_sh, diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, q_r[DSQ_W-1]};
    diff     = rem_sh - {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DSQ_W);
      q_nxt    = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = diff[RAD_W-1:0];
        q_nxt   = {q_r[DSQ_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[RAD_W-1:0];
        q_nxt   = {q_r[DSQ_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r[RAD_W-1:0];

endmodule

FILE: design/bounding_sphere_builder.sv
// Bounding sphere builder: vertices load one per cycle into a 4096-entry store
// (later ones are dropped and flagged). After the transaction marked last, the
// block stalls its input and runs three passes over the store with a single
// shared multiplier: a squared distance per vertex per pass, plus a square root
// on each vertex outside the sphere and the three center-step divides. One result
// transaction follows; the next mesh loads once it has been handed over or
// parked in the output register.
module bounding_sphere_builder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bsb_pkg::COORD_W-1:0]  in_vertex_x,
  input  logic signed [bsb_pkg::COORD_W-1:0]  in_vertex_y,
  input  logic signed [bsb_pkg::COORD_W-1:0]  in_vertex_z,
  input  logic                                in_last_vertex,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bsb_pkg::COORD_W-1:0]  out_center_x,
  output logic signed [bsb_pkg::COORD_W-1:0]  out_center_y,
  output logic signed [bsb_pkg::COORD_W-1:0]  out_center_z,
  output logic        [bsb_pkg::RAD_W-1:0]    out_sphere_radius_out,
  output logic                                out_store_overflow
);
  import bsb_pkg::*;

  vec3_t mem [MAX_VERTICES];
  vec3_t rd_data_r;
  logic  rd_en;
  logic [ADDR_W-1:0] rd_addr;

  state_t state_r, state_nxt;
  pass_t  pass_r, pass_nxt;
  axis_t  ax_r, ax_nxt;
  logic [CNT_W-1:0] vtx_cnt_r, vtx_cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] idx_inc;
  logic ovf_r, ovf_nxt;
  vec3_t from_r, from_nxt;
  vec3_t best_r, best_nxt;
  vec3_t center_r, center_nxt;
  logic [DSQ_W-1:0] bestd_r, bestd_nxt;
  logic [DSQ_W-1:0] acc_r, acc_nxt;
  logic [DSQ_W-1:0] r2_r, r2_nxt;
  logic [RAD_W-1:0] radius_r, radius_nxt;
  logic [RAD_W-1:0] dist_r, dist_nxt;
  logic neg_r, neg_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [MUL_W-1:0]  mul_a, mul_b;

  logic out_valid_r, out_valid_nxt;
  vec3_t out_c_r, out_c_nxt;
  logic [RAD_W-1:0] out_r_r, out_r_nxt;
  logic out_ovf_r, out_ovf_nxt;

  logic accept;
  vec3_t pt, refp;
  logic signed [COORD_W:0] dsq_diff, grow_t;
  logic [RAD_W:0]   rsum;
  logic [RAD_W-1:0] new_r, grow;
  logic signed [COORD_W:0] mid_x, mid_y, mid_z;
  logic [PROD_W-1:0] prod_mag;
  logic signed [COORD_W+2:0] qs, csum;

  logic sq_start, sq_done, dv_start, dv_done;
  logic [DSQ_W-1:0] sq_in;
  logic [RAD_W-1:0] sq_root, dv_q;

  bsb_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  bsb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (prod_mag[DSQ_W-1:0]),
    .divisor  (dist_r),
    .done     (dv_done),
    .quotient (dv_q)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_LOAD);

  // Vertex store
  always_ff @(posedge clk) begin
    if (accept && (vtx_cnt_r < CNT_W'(MAX_VERTICES))) begin
      mem[vtx_cnt_r[ADDR_W-1:0]] <= '{x: in_vertex_x, y: in_vertex_y, z: in_vertex_z};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_en   = (state_r == ST_FIRST) || (state_r == ST_RD);
  assign rd_addr = (state_r == ST_FIRST) ? '0 : idx_r[ADDR_W-1:0];

  // Shared multiplier
  assign pt       = (pass_r == PASS_DD) ? best_r : rd_data_r;
  assign refp     = (pass_r == PASS_GROW) ? center_r : from_r;
  assign dsq_diff = (COORD_W+1)'(axis_of(pt, ax_r)) - (COORD_W+1)'(axis_of(refp, ax_r));
  assign grow_t   = (COORD_W+1)'(axis_of(rd_data_r, ax_r))
                  - (COORD_W+1)'(axis_of(center_r, ax_r));
  assign rsum     = {1'b0, radius_r} + {1'b0, dist_r};
  assign new_r    = rsum[RAD_W:1];
  assign grow     = new_r - radius_r;

  always_comb begin
    mul_a = MUL_W'(dsq_diff);
    mul_b = MUL_W'(dsq_diff);
    case (state_r)
      ST_R2: begin
        mul_a = {1'b0, radius_r};
        mul_b = {1'b0, radius_r};
      end
      ST_GMUL: begin
        mul_a = MUL_W'(grow_t);
        mul_b = {1'b0, grow};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign qs       = neg_r ? -(COORD_W+3)'({1'b0, dv_q}) : (COORD_W+3)'({1'b0, dv_q});
  assign csum     = (COORD_W+3)'(axis_of(center_r, ax_r)) + qs;
  assign mid_x    = ((COORD_W+1)'(from_r.x) + (COORD_W+1)'(best_r.x)) >>> 1;
  assign mid_y    = ((COORD_W+1)'(from_r.y) + (COORD_W+1)'(best_r.y)) >>> 1;
  assign mid_z    = ((COORD_W+1)'(from_r.z) + (COORD_W+1)'(best_r.z)) >>> 1;
  assign idx_inc  = idx_r + CNT_W'(1);
  assign sq_in    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      pass_r      <= PASS_A;
      ax_r        <= AX_X;
      vtx_cnt_r   <= '0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      ax_r        <= ax_nxt;
      vtx_cnt_r   <= vtx_cnt_nxt;
      idx_r       <= idx_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    from_r   <= from_nxt;
    best_r   <= best_nxt;
    center_r <= center_nxt;
    bestd_r  <= bestd_nxt;
    acc_r    <= acc_nxt;
    r2_r     <= r2_nxt;
    radius_r <= radius_nxt;
    dist_r   <= dist_nxt;
    neg_r    <= neg_nxt;
    out_c_r  <= out_c_nxt;
    out_r_r  <= out_r_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    ax_nxt        = ax_r;
    vtx_cnt_nxt   = vtx_cnt_r;
    idx_nxt       = idx_r;
    ovf_nxt       = ovf_r;
    from_nxt      = from_r;
    best_nxt      = best_r;
    center_nxt    = center_r;
    bestd_nxt     = bestd_r;
    acc_nxt       = acc_r;
    r2_nxt        = r2_r;
    radius_nxt    = radius_r;
    dist_nxt      = dist_r;
    neg_nxt       = neg_r;
    out_c_nxt     = out_c_r;
    out_r_nxt     = out_r_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    sq_start      = 1'b0;
    dv_start      = 1'b0;

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (vtx_cnt_r < CNT_W'(MAX_VERTICES)) begin
            vtx_cnt_nxt = vtx_cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_vertex) begin
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_FIRST: state_nxt = ST_FIRSTW;
      ST_FIRSTW: begin
        from_nxt  = rd_data_r;
        best_nxt  = rd_data_r;
        bestd_nxt = '0;
        idx_nxt   = '0;
        pass_nxt  = PASS_A;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        ax_nxt    = AX_X;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        // accumulate the previous axis while squaring this one
        acc_nxt = (ax_r == AX_X) ? '0 : acc_r + prod_r[DSQ_W-1:0];
        if (ax_r == AX_Z) begin
          state_nxt = ST_SUM;
        end else begin
          ax_nxt = axis_t'(ax_r + 2'd1);
        end
      end
      ST_SUM: begin
        acc_nxt   = acc_r + prod_r[DSQ_W-1:0];
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        case (pass_r)
          PASS_A, PASS_B: begin
            idx_nxt   = idx_inc;
            state_nxt = ST_RD;
            if (acc_r > bestd_r) begin
              bestd_nxt = acc_r;
              best_nxt  = pt;
            end
            if (idx_inc == vtx_cnt_r) begin
              if (pass_r == PASS_A) begin
                from_nxt  = best_nxt;
                bestd_nxt = '0;
                idx_nxt   = '0;
                pass_nxt  = PASS_B;
              end else begin
                state_nxt = ST_INIT;
              end
            end
          end
          PASS_DD: begin
            sq_start  = 1'b1;
            state_nxt = ST_SQRT;
          end
          default: begin
            idx_nxt = idx_inc;
            if (acc_r > r2_r) begin
              sq_start  = 1'b1;
              state_nxt = ST_SQRT;
            end else if (idx_inc == vtx_cnt_r) begin
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_RD;
            end
          end
        endcase
      end
      ST_INIT: begin
        center_nxt.x = mid_x[COORD_W-1:0];
        center_nxt.y = mid_y[COORD_W-1:0];
        center_nxt.z = mid_z[COORD_W-1:0];
        pass_nxt     = PASS_DD;
        ax_nxt       = AX_X;
        state_nxt    = ST_SQ;
      end
      ST_SQRT: begin
        if (sq_done) begin
          if (pass_r == PASS_DD) begin
            radius_nxt = sq_root >> 1;
            idx_nxt    = '0;
            pass_nxt   = PASS_GROW;
            state_nxt  = ST_R2;
          end else begin
            dist_nxt  = sq_root;
            ax_nxt    = AX_X;
            state_nxt = ST_GMUL;
          end
        end
      end
      ST_R2: state_nxt = ST_R2W;
      ST_R2W: begin
        r2_nxt    = prod_r[DSQ_W-1:0];
        state_nxt = (idx_r == vtx_cnt_r) ? ST_FIN : ST_RD;
      end
      ST_GMUL: state_nxt = ST_DIVS;
      ST_DIVS: begin
        dv_start  = 1'b1;
        neg_nxt   = prod_r[PROD_W-1];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (dv_done) begin
          case (ax_r)
            AX_X:    center_nxt.x = sat_coord(csum);
            AX_Y:    center_nxt.y = sat_coord(csum);
            default: center_nxt.z = sat_coord(csum);
          endcase
          if (ax_r == AX_Z) begin
            radius_nxt = new_r;
            state_nxt  = ST_R2;
          end else begin
            ax_nxt    = axis_t'(ax_r + 2'd1);
            state_nxt = ST_GMUL;
          end
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_c_nxt     = center_r;
          out_r_nxt     = radius_r;
          out_ovf_nxt   = ovf_r;
          vtx_cnt_nxt   = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_center_x          = out_c_r.x;
  assign out_center_y          = out_c_r.y;
  assign out_center_z          = out_c_r.z;
  assign out_sphere_radius_out = out_r_r;
  assign out_store_overflow    = out_ovf_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vtx_cnt_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count past store depth");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (idx_r < vtx_cnt_r))
    else $error("store read beyond loaded vertices");

  a_r2_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD && pass_r == PASS_GROW) |->
      (r2_r == DSQ_W'(radius_r) * DSQ_W'(radius_r)))
    else $error("squared radius out of step with radius");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result raised outside the finish step");
`endif

endmodule

FILE: dv/bounding_sphere_builder_tb.sv
// Self-checking testbench for bounding_sphere_builder: drives meshes of vertices,
// predicts each bounding sphere in place and compares every result transaction.
// Depends on bsb_pkg and the design folder RTL only.
`timescale 1ns / 100ps

module bounding_sphere_builder_tb;
  import bsb_pkg::*;

  localparam int      CLK_HALF   = 4;
  localparam longint  CYCLE_CAP  = 64'd8_000_000;
  localparam longint  C_MAX      = 64'sd8388607;
  localparam longint  C_MIN      = -64'sd8388608;
  localparam int      RAND_ITEMS = 730;
  localparam int      HOLD_LEN   = 2500;

  typedef struct {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    logic [RAD_W-1:0]   rad;
    logic               ovf;
  } sphere_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
    bit                        typed;
    sphere_t                   sph;
  } vtx_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_vertex_x;
  logic signed [COORD_W-1:0] in_vertex_y;
  logic signed [COORD_W-1:0] in_vertex_z;
  logic                      in_last_vertex;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COORD_W-1:0] out_center_x;
  logic signed [COORD_W-1:0] out_center_y;
  logic signed [COORD_W-1:0] out_center_z;
  logic [RAD_W-1:0]          out_sphere_radius_out;
  logic                      out_store_overflow;

  bounding_sphere_builder u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_vertex_x           (in_vertex_x),
    .in_vertex_y           (in_vertex_y),
    .in_vertex_z           (in_vertex_z),
    .in_last_vertex        (in_last_vertex),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_center_x          (out_center_x),
    .out_center_y          (out_center_y),
    .out_center_z          (out_center_z),
    .out_sphere_radius_out (out_sphere_radius_out),
    .out_store_overflow    (out_store_overflow)
  );

  // sphere model state
  longint          mesh_pts [MAX_VERTICES][3];
  int unsigned     mesh_cnt;
  bit              mesh_ovf;
  longint          far_a [3];
  longint          far_b [3];
  longint          sph_ctr [3];
  longint unsigned sph_rad;

  sphere_t pending_spheres [$];
  int      mismatches;
  int      spheres_seen;
  longint  cycles;
  bit      quiet;
  bit      hold_done;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic longint sat_axis(longint v);
    if (v > C_MAX) return C_MAX;
    if (v < C_MIN) return C_MIN;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned dist_sq_to(int idx, longint q [3]);
    longint unsigned s;
    longint d;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      d = mesh_pts[idx][k] - q[k];
      s += longint'(d * d);
    end
    return s;
  endfunction

  task automatic farthest_pt(input longint from [3], output longint best [3]);
    longint unsigned bd;
    longint unsigned d;
    best = from;
    bd = 0;
    for (int i = 0; i < mesh_cnt; i++) begin
      d = dist_sq_to(i, from);
      if (d > bd) begin
        bd = d;
        for (int k = 0; k < 3; k++) best[k] = mesh_pts[i][k];
      end
    end
  endtask

  task automatic fit_sphere(output sphere_t res);
    longint          first [3];
    longint          s;
    longint          df;
    longint unsigned dd;
    longint unsigned r2;
    longint unsigned d;
    longint unsigned dist_v;
    longint unsigned nr;
    longint          grow;
    longint          t;
    for (int k = 0; k < 3; k++) first[k] = mesh_pts[0][k];
    farthest_pt(first, far_a);
    farthest_pt(far_a, far_b);
    dd = 0;
    for (int k = 0; k < 3; k++) begin
      s = far_a[k] + far_b[k];
      df = far_b[k] - far_a[k];
      sph_ctr[k] = sat_axis((s - (s & 1)) / 2);
      dd += longint'(df * df);
    end
    sph_rad = floor_sqrt(dd) >> 1;
    r2 = sph_rad * sph_rad;
    for (int i = 0; i < mesh_cnt; i++) begin
      d = dist_sq_to(i, sph_ctr);
      if (d > r2) begin
        dist_v = floor_sqrt(d);
        nr = (sph_rad + dist_v) >> 1;
        grow = longint'(nr - sph_rad);
        for (int k = 0; k < 3; k++) begin
          t = mesh_pts[i][k] - sph_ctr[k];
          sph_ctr[k] = sat_axis(sph_ctr[k] + (t * grow) / longint'(dist_v));
        end
        sph_rad = nr & 64'h3FFFFFF;
        r2 = sph_rad * sph_rad;
      end
    end
    res.cx  = sph_ctr[0][COORD_W-1:0];
    res.cy  = sph_ctr[1][COORD_W-1:0];
    res.cz  = sph_ctr[2][COORD_W-1:0];
    res.rad = sph_rad[RAD_W-1:0];
    res.ovf = mesh_ovf;
  endtask

  // model one accepted vertex; returns 1 when it closes a mesh
  task automatic take_vertex(input vtx_row_t v, output bit done, output sphere_t res);
    done = 1'b0;
    if (mesh_cnt < MAX_VERTICES) begin
      mesh_pts[mesh_cnt][0] = v.x;
      mesh_pts[mesh_cnt][1] = v.y;
      mesh_pts[mesh_cnt][2] = v.z;
      mesh_cnt++;
    end else begin
      mesh_ovf = 1'b1;
    end
    if (v.last) begin
      fit_sphere(res);
      done = 1'b1;
      mesh_cnt = 0;
      mesh_ovf = 1'b0;
    end
  endtask

  task automatic send_vertex(input vtx_row_t v);
    bit      done;
    sphere_t res;
    int      gap;
    in_valid       <= 1'b1;
    in_vertex_x    <= v.x;
    in_vertex_y    <= v.y;
    in_vertex_z    <= v.z;
    in_last_vertex <= v.last;
    do @(posedge clk); while (in_stall !== 1'b0);
    take_vertex(v, done, res);
    if (done) pending_spheres.push_back(v.typed ? v.sph : res);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
    case (mode)
      0:       return COORD_W'($urandom());
      1:       return $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 24'sh7FFFFF;
          1:       return 24'sh800000;
          2:       return 24'sh000000;
          default: return 24'shFFFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic vtx_row_t rand_vertex(int mode, logic last);
    vtx_row_t v;
    v.x = rand_coord(mode);
    v.y = rand_coord(mode);
    v.z = rand_coord(mode);
    v.last = last;
    v.typed = 1'b0;
    v.sph = '{default: '0};
    return v;
  endfunction

  function automatic vtx_row_t row(int x, int y, int z, bit last, bit typed,
                                   int cx = 0, int cy = 0, int cz = 0, int r = 0);
    vtx_row_t v;
    v.x = x[COORD_W-1:0];
    v.y = y[COORD_W-1:0];
    v.z = z[COORD_W-1:0];
    v.last = last;
    v.typed = typed;
    v.sph.cx = cx[COORD_W-1:0];
    v.sph.cy = cy[COORD_W-1:0];
    v.sph.cz = cz[COORD_W-1:0];
    v.sph.rad = r[RAD_W-1:0];
    v.sph.ovf = 1'b0;
    return v;
  endfunction

  // result checker and receiver idling
  int stall_left;
  int hold_left;
  always @(posedge clk) begin
    sphere_t want;
    if (rst_n && out_valid && !out_stall) begin
      spheres_seen++;
      if (pending_spheres.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sphere at cycle %0d", cycles);
      end else begin
        want = pending_spheres.pop_front();
        if (out_center_x !== want.cx || out_center_y !== want.cy ||
            out_center_z !== want.cz || out_sphere_radius_out !== want.rad ||
            out_store_overflow !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sphere %0d: exp c=(%h,%h,%h) r=%h ov=%b got c=(%h,%h,%h) r=%h ov=%b",
                     spheres_seen, want.cx, want.cy, want.cz, want.rad, want.ovf,
                     out_center_x, out_center_y, out_center_z,
                     out_sphere_radius_out, out_store_overflow);
        end
      end
    end
    // hold off once for a long stretch so the block fills up behind its output
    if (!hold_done && spheres_seen == 12) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    vtx_row_t directed [$];
    int       sent;
    int       meshes;
    int       n;
    int       mode;
    mesh_cnt = 0;
    mesh_ovf = 1'b0;
    far_a = '{default: 0};
    far_b = '{default: 0};
    sph_ctr = '{default: 0};
    sph_rad = 0;
    mismatches = 0;
    spheres_seen = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_done = 1'b0;
    stall_left = 0;
    hold_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_vertex_x = '0;
    in_vertex_y = '0;
    in_vertex_z = '0;
    in_last_vertex = 1'b0;
    out_stall = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // single vertex at the extremes: sphere of radius zero on it
    directed.push_back(row(8388607, -8388608, 0, 1, 1, 8388607, -8388608, 0, 0));
    directed.push_back(row(-8388608, 8388607, -1, 1, 1, -8388608, 8388607, -1, 0));
    // two points on an axis: center midway, boundary point is not outside
    directed.push_back(row(0, 0, 0, 0, 0));
    directed.push_back(row(8192, 0, 0, 1, 1, 4096, 0, 0, 4096));
    // opposite corners of the coordinate range
    directed.push_back(row(8388607, 8388607, 8388607, 0, 0));
    directed.push_back(row(-8388608, -8388608, -8388608, 1, 0));
    // repeated vertex
    directed.push_back(row(5, 5, 5, 0, 0));
    directed.push_back(row(5, 5, 5, 0, 0));
    directed.push_back(row(5, 5, 5, 1, 1, 5, 5, 5, 0));
    // odd sum in the initial center: round toward minus infinity
    directed.push_back(row(-3, 0, 0, 0, 0));
    directed.push_back(row(0, 0, 0, 1, 0));
    // points that grow the sphere and shift its center
    directed.push_back(row(0, 0, 0, 0, 0));
    directed.push_back(row(40960, 0, 0, 0, 0));
    directed.push_back(row(20480, 40960, 0, 0, 0));
    directed.push_back(row(20480, -20480, 40960, 0, 0));
    directed.push_back(row(-40960, -40960, -40960, 1, 0));
    foreach (directed[i]) send_vertex(directed[i]);

    sent = 0;
    meshes = 0;
    while (sent < RAND_ITEMS) begin
      if (meshes == 8) begin
        // pause the sender until the block has drained
        in_valid <= 1'b0;
        wait (pending_spheres.size() == 0);
        @(posedge clk);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        send_vertex(rand_vertex(mode, i == n - 1));
        sent++;
      end
      meshes++;
      if (sent > RAND_ITEMS - 80) quiet = 1'b1;
    end
    in_valid <= 1'b0;
    wait (pending_spheres.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_spheres.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
design/bsb_pkg.sv
design/bsb_isqrt.sv
design/bsb_div.sv
design/bounding_sphere_builder.sv
dv/bounding_sphere_builder_tb.sv
